FILE: rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, codes and character helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int unsigned TypeDepth  = 5;
  localparam int unsigned CheckDepth = 2;

  localparam logic [7:0] HeadReset = 8'd36;
  localparam logic [7:0] TailReset = 8'd10;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;

  localparam logic [0:0] CFG_HEAD = 1'b0;
  localparam logic [0:0] CFG_TAIL = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

  localparam logic [1:0] MSG_NONE = 2'd0;
  localparam logic [1:0] MSG_RMC  = 2'd1;
  localparam logic [1:0] MSG_GGA  = 2'd2;
  localparam logic [1:0] MSG_GSA  = 2'd3;

  // star_count saturates at two, type_length at six, check_length at three
  localparam logic [1:0] StarSat      = 2'd2;
  localparam logic [2:0] TypeLenSat   = 3'd6;
  localparam logic [1:0] CheckLenSat  = 2'd3;

  typedef struct packed {
    logic [1:0]                     star_count;
    logic [7:0]                     running_xor;
    logic [TypeDepth-1:0][7:0]      type_chars;
    logic [2:0]                     type_length;
    logic [CheckDepth-1:0][7:0]     check_chars;
    logic [1:0]                     check_length;
  } frame_t;

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'd0, v};
    end
    return 8'h41 + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [1:0] name_code(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2);
    if (c0 == "R" && c1 == "M" && c2 == "C") begin
      return MSG_RMC;
    end
    if (c0 == "G" && c1 == "G" && c2 == "A") begin
      return MSG_GGA;
    end
    if (c0 == "G" && c1 == "S" && c2 == "A") begin
      return MSG_GSA;
    end
    return MSG_NONE;
  endfunction

  // optional GP/GL/GN talker prefix ahead of the three-letter name
  function automatic logic [1:0] classify(input logic [TypeDepth-1:0][7:0] ch,
                                          input logic [2:0] len);
    if (len == 3'd3) begin
      return name_code(ch[0], ch[1], ch[2]);
    end
    if (len == 3'd5 && ch[0] == "G" && (ch[1] == "P" || ch[1] == "L" || ch[1] == "N")) begin
      return name_code(ch[2], ch[3], ch[4]);
    end
    return MSG_NONE;
  endfunction

endpackage

FILE: rtl/nmea_sentence_checker_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// NMEA 0183 sentence framing, checksum check and message type recognition.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, back to back, while no result is
// held. Each byte is registered in an input register, updates the sentence
// state in one pass and, when it is the tail byte of a framed sentence, loads
// the result register. A held result stalls the byte in the input register;
// one more byte is still taken while a result waits. The user must write head
// and tail characters only while idle; the block itself does not enforce it.
module nmea_sentence_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [1:0] out_msg_type,
  output logic [7:0] out_computed_sum
);

  logic [7:0]      head_r;
  logic [7:0]      tail_r;
  logic            byte_valid_r;
  logic [7:0]      byte_r;
  logic            advance;
  logic            step;
  logic            done;
  nsc_pkg::frame_t frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= nsc_pkg::HeadReset;
      tail_r <= nsc_pkg::TailReset;
    end else if (cfg_we) begin
      case (cfg_index)
        nsc_pkg::CFG_HEAD: head_r <= cfg_wdata;
        nsc_pkg::CFG_TAIL: tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign step     = byte_valid_r && advance;
  assign in_ready = !byte_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  nsc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_r),
    .head_char (head_r),
    .tail_char (tail_r),
    .done      (done),
    .frame     (frame)
  );

  nsc_eval u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .done             (done),
    .frame            (frame),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_msg_type     (out_msg_type),
    .out_computed_sum (out_computed_sum)
  );

`ifndef SYNTHESIS
  a_type_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != nsc_pkg::STATUS_OK |-> out_msg_type == nsc_pkg::MSG_NONE)
    else $error("message type reported with a failing status");

  a_ok_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nsc_pkg::STATUS_OK |-> out_msg_type != nsc_pkg::MSG_NONE)
    else $error("ok status without a recognized message type");

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the result register is free");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_computed_sum))
    else $error("held result lost or overwritten");
`endif

endmodule

FILE: rtl/nsc_frame.sv
// ----------------------------------------------------------------------------
// nsc_frame
// Sentence framing and per-byte state update: checksum, token and check part.
// ----------------------------------------------------------------------------
module nsc_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        head_char,
  input  logic [7:0]        tail_char,
  output logic              done,
  output nsc_pkg::frame_t   frame
);

  logic            in_sentence_r, in_sentence_nxt;
  logic            seen_text_r, seen_text_nxt;
  logic            type_closed_r, type_closed_nxt;
  logic            check_spaced_r, check_spaced_nxt;
  logic [1:0]      star_count_r, star_count_nxt;
  logic [7:0]      running_xor_r, running_xor_nxt;
  logic [2:0]      type_length_r, type_length_nxt;
  logic [1:0]      check_length_r, check_length_nxt;
  logic [nsc_pkg::TypeDepth-1:0][7:0]  type_chars_r, type_chars_nxt;
  logic [nsc_pkg::CheckDepth-1:0][7:0] check_chars_r, check_chars_nxt;

  assign frame.star_count   = star_count_r;
  assign frame.running_xor  = running_xor_r;
  assign frame.type_chars   = type_chars_r;
  assign frame.type_length  = type_length_r;
  assign frame.check_chars  = check_chars_r;
  assign frame.check_length = check_length_r;

  assign done = step && in_sentence_r && (rx_byte == tail_char);

  always_comb begin
    in_sentence_nxt  = in_sentence_r;
    seen_text_nxt    = seen_text_r;
    type_closed_nxt  = type_closed_r;
    check_spaced_nxt = check_spaced_r;
    star_count_nxt   = star_count_r;
    running_xor_nxt  = running_xor_r;
    type_length_nxt  = type_length_r;
    check_length_nxt = check_length_r;
    type_chars_nxt   = type_chars_r;
    check_chars_nxt  = check_chars_r;
    if (!in_sentence_r) begin
      if (rx_byte == head_char) begin
        in_sentence_nxt  = 1'b1;
        seen_text_nxt    = 1'b0;
        type_closed_nxt  = 1'b0;
        check_spaced_nxt = 1'b0;
        star_count_nxt   = 2'd0;
        running_xor_nxt  = 8'd0;
        type_length_nxt  = 3'd0;
        check_length_nxt = 2'd0;
      end
    end else if (rx_byte == tail_char) begin
      in_sentence_nxt = 1'b0;
    end else if (seen_text_r || !nsc_pkg::is_space(rx_byte)) begin
      seen_text_nxt = 1'b1;
      if (star_count_r == 2'd0) begin
        if (rx_byte == nsc_pkg::ChStar) begin
          star_count_nxt  = 2'd1;
          type_closed_nxt = 1'b1;
        end else begin
          running_xor_nxt = running_xor_r ^ rx_byte;
          if (!type_closed_r) begin
            if (rx_byte == nsc_pkg::ChComma) begin
              type_closed_nxt = 1'b1;
            end else begin
              for (int i = 0; i < nsc_pkg::TypeDepth; i++) begin
                if (type_length_r == 3'(i)) begin
                  type_chars_nxt[i] = rx_byte;
                end
              end
              if (type_length_r < nsc_pkg::TypeLenSat) begin
                type_length_nxt = type_length_r + 3'd1;
              end
            end
          end
        end
      end else if (rx_byte == nsc_pkg::ChStar) begin
        star_count_nxt = nsc_pkg::StarSat;
      end else if (nsc_pkg::is_space(rx_byte)) begin
        check_spaced_nxt = 1'b1;
      end else if (check_spaced_r) begin
        check_length_nxt = nsc_pkg::CheckLenSat;
      end else begin
        if (check_length_r < 2'd2) begin
          check_chars_nxt[check_length_r[0]] = rx_byte;
        end
        if (check_length_r < nsc_pkg::CheckLenSat) begin
          check_length_nxt = check_length_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r  <= 1'b0;
      seen_text_r    <= 1'b0;
      type_closed_r  <= 1'b0;
      check_spaced_r <= 1'b0;
      star_count_r   <= 2'd0;
      running_xor_r  <= 8'd0;
      type_length_r  <= 3'd0;
      check_length_r <= 2'd0;
    end else if (step) begin
      in_sentence_r  <= in_sentence_nxt;
      seen_text_r    <= seen_text_nxt;
      type_closed_r  <= type_closed_nxt;
      check_spaced_r <= check_spaced_nxt;
      star_count_r   <= star_count_nxt;
      running_xor_r  <= running_xor_nxt;
      type_length_r  <= type_length_nxt;
      check_length_r <= check_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      type_chars_r  <= type_chars_nxt;
      check_chars_r <= check_chars_nxt;
    end
  end

endmodule

FILE: rtl/nsc_eval.sv
// ----------------------------------------------------------------------------
// nsc_eval
// Verdict at the tail byte and the result register of the output channel.
// ----------------------------------------------------------------------------
module nsc_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              done,
  input  nsc_pkg::frame_t   frame,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [1:0]        out_msg_type,
  output logic [7:0]        out_computed_sum
);

  logic       out_valid_r;
  logic [1:0] status_r, status_nxt;
  logic [1:0] msg_type_r, msg_type_nxt;
  logic [7:0] sum_r;
  logic [1:0] type_code;

  assign type_code = nsc_pkg::classify(frame.type_chars, frame.type_length);

  always_comb begin
    msg_type_nxt = nsc_pkg::MSG_NONE;
    if (frame.star_count != 2'd1 || frame.check_length == 2'd0) begin
      status_nxt = nsc_pkg::STATUS_MALFORMED;
    end else if (frame.check_length != 2'd2 ||
                 frame.check_chars[0] != nsc_pkg::hex_char(frame.running_xor[7:4]) ||
                 frame.check_chars[1] != nsc_pkg::hex_char(frame.running_xor[3:0])) begin
      status_nxt = nsc_pkg::STATUS_MISMATCH;
    end else if (type_code == nsc_pkg::MSG_NONE) begin
      status_nxt = nsc_pkg::STATUS_UNKNOWN;
    end else begin
      status_nxt   = nsc_pkg::STATUS_OK;
      msg_type_nxt = type_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r   <= status_nxt;
      msg_type_r <= msg_type_nxt;
      sum_r      <= frame.running_xor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_msg_type     = msg_type_r;
  assign out_computed_sum = sum_r;

endmodule
